@@ rtl/rrt_pkg.sv @@
// shared types and constants of the round-robin thread table
`default_nettype none
package rrt_pkg;

	localparam int SLOTS   = 64;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = SLOT_W + 1;
	localparam int ID_BITS = 16;

	// fixed port widths
	localparam int OPC_W      = 2;
	localparam int ID_W       = 16;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 6;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [ID_BITS-1:0] ID_RST_SLOT0 = ID_BITS'(1);
	localparam logic [ID_BITS-1:0] ID_RST_NEXT  = ID_BITS'(2);

	typedef enum logic [OPC_W-1:0] {
		OP_CREATE = 2'd0,
		OP_YIELD  = 2'd1,
		OP_EXIT   = 2'd2,
		OP_JOIN   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_MISS  = 2'd1,
		STS_WAIT  = 2'd2,
		STS_NORUN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SS_UNUSED   = 2'd0,
		SS_RUNNABLE = 2'd1,
		SS_RUNNING  = 2'd2,
		SS_DONE     = 2'd3
	} slot_st_t;

	typedef struct packed {
		op_t                op;
		logic [ID_BITS-1:0] target;
	} cmd_t;

	typedef struct packed {
		status_t                 status;
		logic [ID_W-1:0]         rid;
		logic [SLOT_OUT_W-1:0]   running;
		logic                    switched;
		logic [SLOT_OUT_W-1:0]   previous;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/rrt_front.sv @@
// command intake stage: accepts and decodes commands toward the queue
`default_nettype none
module rrt_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [rrt_pkg::OPC_W-1:0]   opcode,
	input  wire logic [rrt_pkg::ID_W-1:0]    target_id,
	output logic                             full,
	output rrt_pkg::cmd_t                    cmd,
	output logic                             cmd_vld,
	input  wire logic                        q_full
);

	rrt_pkg::cmd_t cmd_s1;
	rrt_pkg::cmd_t cmd_dec;
	logic          vld_s1;
	logic          accept;

	always_comb begin
		unique case (opcode)
			2'd0:    cmd_dec.op = rrt_pkg::OP_CREATE;
			2'd1:    cmd_dec.op = rrt_pkg::OP_YIELD;
			2'd2:    cmd_dec.op = rrt_pkg::OP_EXIT;
			default: cmd_dec.op = rrt_pkg::OP_JOIN;
		endcase
		// only join uses the id
		cmd_dec.target = (cmd_dec.op == rrt_pkg::OP_JOIN) ?
			rrt_pkg::ID_BITS'(target_id) : '0;
	end

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_dec;
		end
	end

	assign cmd     = cmd_s1;
	assign cmd_vld = vld_s1 && !q_full;

endmodule
`default_nettype wire

@@ rtl/rrt_queue.sv @@
// short command queue between intake and scheduler
`default_nettype none
module rrt_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire rrt_pkg::cmd_t wr_cmd,
	output logic               full,
	input  wire logic          rd_en,
	output rrt_pkg::cmd_t      rd_cmd,
	output logic               rd_vld
);

	rrt_pkg::cmd_t                entry_q [rrt_pkg::QDEPTH];
	logic [rrt_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [rrt_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [rrt_pkg::QPTR_W:0]     count_q;
	logic                         do_wr;
	logic                         do_rd;

	assign full   = (count_q == (rrt_pkg::QPTR_W+1)'(rrt_pkg::QDEPTH));
	assign rd_vld = (count_q != '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && rd_vld;
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == rrt_pkg::QPTR_W'(rrt_pkg::QDEPTH-1)) ?
					'0 : wr_ptr_q + rrt_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == rrt_pkg::QPTR_W'(rrt_pkg::QDEPTH-1)) ?
					'0 : rd_ptr_q + rrt_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (rrt_pkg::QPTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (rrt_pkg::QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule
`default_nettype wire

@@ rtl/rrt_back.sv @@
// scheduler engine: slot table, sequential scan and table updates
`default_nettype none
module rrt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rrt_pkg::cmd_t cmd,
	input  wire logic          cmd_vld,
	output logic               cmd_pop,
	output rrt_pkg::result_t   res,
	output logic               res_vld,
	input  wire logic          res_pop
);

	localparam int SW = rrt_pkg::SLOT_W;
	localparam int CW = rrt_pkg::CNT_W;
	localparam int IW = rrt_pkg::ID_BITS;

	typedef enum logic [8:0] {
		B_IDLE       = 9'b000000001,
		B_EXIT_WR    = 9'b000000010,
		B_SCAN       = 9'b000000100,
		B_DECIDE     = 9'b000001000,
		B_CREATE_WR  = 9'b000010000,
		B_FREE_WR    = 9'b000100000,
		B_DEMOTE_WR  = 9'b001000000,
		B_PROMOTE_WR = 9'b010000000,
		B_EMIT       = 9'b100000000
	} bst_t;

	typedef enum logic [1:0] {
		SC_UNUSED   = 2'd0,
		SC_RUNNABLE = 2'd1,
		SC_ID       = 2'd2
	} scan_t;

	// slot table
	rrt_pkg::slot_st_t  st_mem [rrt_pkg::SLOTS];
	logic [IW-1:0]      id_mem [rrt_pkg::SLOTS];
	logic [rrt_pkg::SLOTS-1:0] st_vld_q;
	logic               id0_wr_q;

	bst_t               state_q;
	rrt_pkg::op_t       op_q;
	logic [IW-1:0]      target_q;
	logic [SW-1:0]      prev_q;
	logic [SW-1:0]      cur_q;
	rrt_pkg::slot_st_t  cur_st_q;
	logic [IW-1:0]      cur_id_q;
	logic [IW-1:0]      next_id_q;
	scan_t              kind_q;
	logic [SW-1:0]      base_q;
	logic [CW-1:0]      cnt_q;
	logic               found_q;
	logic [SW-1:0]      fnd_slot_q;
	rrt_pkg::slot_st_t  fnd_st_q;
	logic [IW-1:0]      fnd_id_q;
	logic               join_wait_q;
	logic               create_ok_q;
	logic [IW-1:0]      new_id_q;
	rrt_pkg::status_t   status_q;
	rrt_pkg::result_t   res_q;
	logic               res_vld_q;

	// read pipeline
	logic               rd_issued_s1;
	logic [SW-1:0]      rd_addr_s1;
	rrt_pkg::slot_st_t  st_rd_s1;
	logic               st_vld_s1;
	logic [IW-1:0]      id_rd_s1;

	logic [CW-1:0]      addr_sum;
	logic [SW-1:0]      rd_addr;
	logic [SW-1:0]      yield_base;
	rrt_pkg::slot_st_t  st_eff;
	logic [IW-1:0]      id_eff;
	logic               match;
	logic               hit;
	logic               issue;
	logic               scan_end;
	logic               res_load;

	logic               st_we;
	logic               id_we;
	logic [SW-1:0]      wr_addr;
	rrt_pkg::slot_st_t  st_wdata;

	assign addr_sum   = {1'b0, base_q} + cnt_q;
	assign rd_addr    = (addr_sum >= CW'(rrt_pkg::SLOTS)) ?
		SW'(addr_sum - CW'(rrt_pkg::SLOTS)) : SW'(addr_sum);
	assign yield_base = (cur_q == SW'(rrt_pkg::SLOTS-1)) ? '0 : cur_q + SW'(1);

	// unwritten entries read as their reset contents
	always_comb begin
		if (st_vld_s1) begin
			st_eff = st_rd_s1;
		end else if (rd_addr_s1 == '0) begin
			st_eff = rrt_pkg::SS_RUNNING;
		end else begin
			st_eff = rrt_pkg::SS_UNUSED;
		end
		id_eff = (rd_addr_s1 == '0 && !id0_wr_q) ? rrt_pkg::ID_RST_SLOT0 : id_rd_s1;
		case (kind_q)
			SC_UNUSED:   match = (st_eff == rrt_pkg::SS_UNUSED);
			SC_RUNNABLE: match = (st_eff == rrt_pkg::SS_RUNNABLE);
			SC_ID:       match = (st_eff != rrt_pkg::SS_UNUSED) && (id_eff == target_q);
			default:     match = 1'b0;
		endcase
	end

	assign hit      = (state_q == B_SCAN) && rd_issued_s1 && match;
	assign issue    = (state_q == B_SCAN) && !hit && (cnt_q != CW'(rrt_pkg::SLOTS));
	assign scan_end = (state_q == B_SCAN) && !hit && !issue && !rd_issued_s1;
	assign cmd_pop  = (state_q == B_IDLE) && cmd_vld;
	assign res_load = (state_q == B_EMIT) && (!res_vld_q || res_pop);

	// table write port
	always_comb begin
		st_we    = 1'b0;
		id_we    = 1'b0;
		wr_addr  = fnd_slot_q;
		st_wdata = rrt_pkg::SS_RUNNING;
		unique case (state_q)
			B_EXIT_WR: begin
				st_we    = 1'b1;
				wr_addr  = cur_q;
				st_wdata = rrt_pkg::SS_DONE;
			end
			B_CREATE_WR: begin
				st_we    = 1'b1;
				id_we    = 1'b1;
				st_wdata = rrt_pkg::SS_RUNNABLE;
			end
			B_FREE_WR: begin
				st_we    = 1'b1;
				st_wdata = rrt_pkg::SS_UNUSED;
			end
			B_DEMOTE_WR: begin
				st_we    = (cur_st_q == rrt_pkg::SS_RUNNING);
				wr_addr  = cur_q;
				st_wdata = rrt_pkg::SS_RUNNABLE;
			end
			B_PROMOTE_WR: begin
				st_we    = 1'b1;
				st_wdata = rrt_pkg::SS_RUNNING;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[wr_addr] <= st_wdata;
		end
		if (id_we) begin
			id_mem[wr_addr] <= next_id_q;
		end
		st_rd_s1   <= st_mem[rd_addr];
		id_rd_s1   <= id_mem[rd_addr];
		st_vld_s1  <= st_vld_q[rd_addr];
		rd_addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			st_vld_q     <= '0;
			id0_wr_q     <= 1'b0;
			cur_q        <= '0;
			cur_st_q     <= rrt_pkg::SS_RUNNING;
			cur_id_q     <= rrt_pkg::ID_RST_SLOT0;
			next_id_q    <= rrt_pkg::ID_RST_NEXT;
			cnt_q        <= '0;
			rd_issued_s1 <= 1'b0;
			res_vld_q    <= 1'b0;
			op_q         <= rrt_pkg::OP_CREATE;
			target_q     <= '0;
			prev_q       <= '0;
			kind_q       <= SC_UNUSED;
			base_q       <= '0;
			found_q      <= 1'b0;
			fnd_slot_q   <= '0;
			fnd_st_q     <= rrt_pkg::SS_UNUSED;
			fnd_id_q     <= '0;
			join_wait_q  <= 1'b0;
			create_ok_q  <= 1'b0;
			new_id_q     <= '0;
			status_q     <= rrt_pkg::STS_OK;
			res_q        <= '0;
		end else begin
			if (st_we) begin
				st_vld_q[wr_addr] <= 1'b1;
			end
			if (id_we && wr_addr == '0) begin
				id0_wr_q <= 1'b1;
			end
			rd_issued_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
				res_q.status   <= status_q;
				res_q.rid      <= rrt_pkg::ID_W'(create_ok_q ? new_id_q : cur_id_q);
				res_q.running  <= rrt_pkg::SLOT_OUT_W'(cur_q);
				res_q.switched <= (cur_q != prev_q);
				res_q.previous <= rrt_pkg::SLOT_OUT_W'(prev_q);
			end else if (res_pop) begin
				res_vld_q <= 1'b0;
			end

			unique case (state_q)
				B_IDLE: begin
					if (cmd_vld) begin
						op_q        <= cmd.op;
						target_q    <= cmd.target;
						prev_q      <= cur_q;
						join_wait_q <= 1'b0;
						create_ok_q <= 1'b0;
						cnt_q       <= '0;
						case (cmd.op)
							rrt_pkg::OP_EXIT: begin
								state_q <= B_EXIT_WR;
							end
							rrt_pkg::OP_YIELD: begin
								kind_q  <= SC_RUNNABLE;
								base_q  <= yield_base;
								state_q <= B_SCAN;
							end
							rrt_pkg::OP_CREATE: begin
								kind_q  <= SC_UNUSED;
								base_q  <= '0;
								state_q <= B_SCAN;
							end
							default: begin
								kind_q  <= SC_ID;
								base_q  <= '0;
								state_q <= B_SCAN;
							end
						endcase
					end
				end
				B_EXIT_WR: begin
					cur_st_q <= rrt_pkg::SS_DONE;
					kind_q   <= SC_RUNNABLE;
					base_q   <= yield_base;
					cnt_q    <= '0;
					state_q  <= B_SCAN;
				end
				B_SCAN: begin
					if (hit) begin
						found_q    <= 1'b1;
						fnd_slot_q <= rd_addr_s1;
						fnd_st_q   <= st_eff;
						fnd_id_q   <= id_eff;
						state_q    <= B_DECIDE;
					end else if (scan_end) begin
						found_q <= 1'b0;
						state_q <= B_DECIDE;
					end
				end
				B_DECIDE: begin
					if (op_q == rrt_pkg::OP_CREATE) begin
						if (found_q) begin
							state_q <= B_CREATE_WR;
						end else begin
							status_q <= rrt_pkg::STS_MISS;
							state_q  <= B_EMIT;
						end
					end else if (op_q == rrt_pkg::OP_JOIN && !join_wait_q) begin
						if (!found_q) begin
							status_q <= rrt_pkg::STS_MISS;
							state_q  <= B_EMIT;
						end else if (fnd_st_q == rrt_pkg::SS_DONE) begin
							state_q <= B_FREE_WR;
						end else begin
							// target still alive: give up the cpu and report waiting
							join_wait_q <= 1'b1;
							kind_q      <= SC_RUNNABLE;
							base_q      <= yield_base;
							cnt_q       <= '0;
							state_q     <= B_SCAN;
						end
					end else if (found_q) begin
						state_q <= B_DEMOTE_WR;
					end else begin
						status_q <= join_wait_q ? rrt_pkg::STS_WAIT : rrt_pkg::STS_NORUN;
						state_q  <= B_EMIT;
					end
				end
				B_CREATE_WR: begin
					if (fnd_slot_q == cur_q) begin
						cur_st_q <= rrt_pkg::SS_RUNNABLE;
						cur_id_q <= next_id_q;
					end
					new_id_q    <= next_id_q;
					next_id_q   <= next_id_q + IW'(1);
					create_ok_q <= 1'b1;
					status_q    <= rrt_pkg::STS_OK;
					state_q     <= B_EMIT;
				end
				B_FREE_WR: begin
					if (fnd_slot_q == cur_q) begin
						cur_st_q <= rrt_pkg::SS_UNUSED;
					end
					status_q <= rrt_pkg::STS_OK;
					state_q  <= B_EMIT;
				end
				B_DEMOTE_WR: begin
					state_q <= B_PROMOTE_WR;
				end
				B_PROMOTE_WR: begin
					cur_q    <= fnd_slot_q;
					cur_st_q <= rrt_pkg::SS_RUNNING;
					cur_id_q <= fnd_id_q;
					status_q <= join_wait_q ? rrt_pkg::STS_WAIT : rrt_pkg::STS_OK;
					state_q  <= B_EMIT;
				end
				B_EMIT: begin
					if (res_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign res     = res_q;
	assign res_vld = res_vld_q;

endmodule
`default_nettype wire

@@ rtl/round_robin_thread_table.sv @@
// top level of the round-robin thread table scheduler
// a scan of the slot table visits one slot per cycle
// throughput: one transaction at a time in the scheduler, whose slot table has a
//   single read port; three more commands buffer in the intake stage and queue
// reset: arst_n clears all control at once; the slot table uses per-slot valid bits,
//   so no clearing pass is needed and commands are taken right after reset
`default_nettype none
module round_robin_thread_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// command side
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [rrt_pkg::OPC_W-1:0]        opcode,
	input  wire logic [rrt_pkg::ID_W-1:0]         target_id,
	// result side
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [rrt_pkg::STATUS_W-1:0]          status,
	output logic [rrt_pkg::ID_W-1:0]              result_id,
	output logic [rrt_pkg::SLOT_OUT_W-1:0]        running_slot,
	output logic                                  switched,
	output logic [rrt_pkg::SLOT_OUT_W-1:0]        previous_slot
);

	// intake to queue
	rrt_pkg::cmd_t    fr_cmd;
	logic             fr_vld;
	logic             q_full;

	// queue to scheduler
	rrt_pkg::cmd_t    q_cmd;
	logic             q_vld;
	logic             q_pop;

	// scheduler result register
	rrt_pkg::result_t res;
	logic             res_vld;

	// intake: registers the transaction and decodes the opcode
	rrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.opcode    (opcode),
		.target_id (target_id),
		.full      (full),
		.cmd       (fr_cmd),
		.cmd_vld   (fr_vld),
		.q_full    (q_full)
	);

	// decoupling queue so intake keeps accepting while the scheduler scans
	rrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_vld),
		.wr_cmd (fr_cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_cmd),
		.rd_vld (q_vld)
	);

	// scheduler: owns the slot table, scans it and applies the updates;
	// the result register lets a finished result wait while the next
	// command is already being taken
	rrt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (q_cmd),
		.cmd_vld (q_vld),
		.cmd_pop (q_pop),
		.res     (res),
		.res_vld (res_vld),
		.res_pop (pop)
	);

	// result side looks like the read end of a queue
	assign empty         = !res_vld;
	assign status        = res.status;
	assign result_id     = res.rid;
	assign running_slot  = res.running;
	assign switched      = res.switched;
	assign previous_slot = res.previous;

endmodule
`default_nettype wire

@@ rtl/rrt_checker.sv @@
// port-level checker for the thread table, bound to the top level
`default_nettype none
module rrt_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire logic                             full,
	input  wire logic                             empty,
	input  wire logic                             pop,
	input  wire logic [rrt_pkg::STATUS_W-1:0]     status,
	input  wire logic [rrt_pkg::ID_W-1:0]         result_id,
	input  wire logic [rrt_pkg::SLOT_OUT_W-1:0]   running_slot,
	input  wire logic                             switched,
	input  wire logic [rrt_pkg::SLOT_OUT_W-1:0]   previous_slot
);

	logic [3:0]                         pend_q;
	logic [rrt_pkg::SLOT_OUT_W-1:0]     last_run_q;
	logic                               in_acc;
	logic                               out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			last_run_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				pend_q <= pend_q + 4'd1;
			end else if (out_acc && !in_acc) begin
				pend_q <= pend_q - 4'd1;
			end
			if (out_acc) begin
				last_run_q <= running_slot;
			end
		end
	end

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(result_id)
			&& $stable(running_slot)))
		else $error("result changed while waiting");

	// no result without an accepted command behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != 4'd0))
		else $error("result without a pending command");

	// each result starts where the previous one left the running slot
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (previous_slot == last_run_q))
		else $error("previous slot does not chain");

	// a switch only comes with an ok or wait status (a yield, an exit or a waiting join)
	a_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && switched) |-> ((status == rrt_pkg::STS_OK || status == rrt_pkg::STS_WAIT)
			&& running_slot != previous_slot))
		else $error("switch with wrong status");

endmodule

bind round_robin_thread_table rrt_checker u_rrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.empty         (empty),
	.pop           (pop),
	.status        (status),
	.result_id     (result_id),
	.running_slot  (running_slot),
	.switched      (switched),
	.previous_slot (previous_slot)
);
`default_nettype wire
